[hdl/bfsr_pkg.sv]
`default_nettype none
package bfsr_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAT,
    ST_HDR,
    ST_RD,
    ST_WORD,
    ST_CSUM
  } bfsr_state_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_WORD,
    KIND_CSUM,
    KIND_STAT
  } bfsr_kind_e;

  // status codes carried by a status result
  typedef enum logic [1:0] {
    STAT_NONE,
    STAT_OK,
    STAT_RETRY,
    STAT_FAIL
  } bfsr_status_e;

  // input command codes
  localparam logic CMD_WORD  = 1'b0;
  localparam logic CMD_REPLY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ARCH_MODE      = 2'd0;
  localparam logic [1:0] CFG_BYTES_PER_WORD = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIMIT    = 2'd2;

  // address order modes
  localparam logic [1:0] ARCH_HL  = 2'd0;
  localparam logic [1:0] ARCH_UHL = 2'd1;
  localparam logic [1:0] ARCH_LHU = 2'd2;

  localparam logic [1:0] BPW_THREE = 2'd3;
  localparam logic [7:0] REPLY_OK  = 8'h4B;

  // reset values of the registers
  localparam logic [1:0] ARCH_RESET  = ARCH_HL;
  localparam logic [1:0] BPW_RESET   = 2'd2;
  localparam logic [7:0] LIMIT_RESET = 8'd5;

  // one result item
  typedef struct packed {
    bfsr_kind_e   kind;
    logic [7:0]   byte_a;
    logic [7:0]   byte_b;
    logic [7:0]   byte_c;
    logic [7:0]   byte_d;
    logic [2:0]   byte_count;
    bfsr_status_e status;
    logic         last;
  } bfsr_rslt_t;

endpackage
`default_nettype wire

[hdl/boot_frame_sender_retry_core.sv]
`default_nettype none
// an input item is taken only in the idle state; a new code word gives a header if it
// starts a frame, its word, and the checksum if it completes the frame, one result per
// cycle while the output is not stalled; a retry reply gives a status, then replays the
// frame from the buffer: header, a buffer read step and an emit step per word, checksum
// reset: control state cleared, retry budget 5, registers at defaults; the frame buffer
// has no clearing pass and holds undefined data until written
module boot_frame_sender_retry_core #(
  parameter int FRAME_WORDS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // code_word[23:0], frame_address[47:24], frame_start[48], image_start[49],
  // reply_char[57:50], zero fill[63:58]
  input  wire logic [63:0] s_axis_tdata,
  // cmd[0]
  input  wire logic        s_axis_tuser,
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // byte_a[7:0], byte_b[15:8], byte_c[23:16], byte_d[31:24], byte_count[34:32],
  // status[36:35], zero fill[39:37]
  output logic [39:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_data_i
);
  import bfsr_pkg::*;

  localparam int AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_WORDS - 1);
  localparam logic [7:0] CNT_TWO   = 8'((2 * FRAME_WORDS) % 256);
  localparam logic [7:0] CNT_THREE = 8'((3 * FRAME_WORDS) % 256);

  // input fields
  logic        in_cmd;
  logic [23:0] in_code_word;
  logic [23:0] in_frame_address;
  logic        in_frame_start;
  logic        in_image_start;
  logic [7:0]  in_reply_char;

  assign in_cmd           = s_axis_tuser;
  assign in_code_word     = s_axis_tdata[23:0];
  assign in_frame_address = s_axis_tdata[47:24];
  assign in_frame_start   = s_axis_tdata[48];
  assign in_image_start   = s_axis_tdata[49];
  assign in_reply_char    = s_axis_tdata[57:50];

  bfsr_state_e  state_q, state_d;
  logic         out_valid_q, out_valid_d;
  bfsr_rslt_t   out_q;
  bfsr_rslt_t   rslt;
  logic [7:0]   sum_q, sum_d;
  logic [7:0]   retries_q, retries_d;
  logic [AW-1:0] widx_q, widx_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic         awaiting_q, awaiting_d;
  logic [23:0]  saved_addr_q, saved_addr_d;
  logic [1:0]   arch_q, arch_d;
  logic [1:0]   bpw_q, bpw_d;
  logic [7:0]   limit_q, limit_d;
  logic         replay_q, replay_d;
  logic         csum_after_q, csum_after_d;
  bfsr_status_e stat_q, stat_d;
  logic [23:0]  cw_q;
  logic [23:0]  rdata_q;

  logic          in_acc;
  logic          slot_free;
  logic          emit;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          rd_en;
  logic          start;
  logic          complete;
  logic [AW-1:0] widx_eff;
  logic [7:0]    retries_eff;
  logic [23:0]   word_data;
  logic [7:0]    sum_add;
  logic          bpw3;
  logic [7:0]    cnt_byte;

  logic [23:0] mem [FRAME_WORDS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign bpw3          = (bpw_q == BPW_THREE);
  assign cnt_byte      = bpw3 ? CNT_THREE : CNT_TWO;
  assign word_data     = replay_q ? rdata_q : cw_q;

  // result formatting for the current sequencer step
  always_comb begin
    rslt = '0;
    unique case (state_q)
      ST_STAT: begin
        rslt.kind   = KIND_STAT;
        rslt.status = stat_q;
        rslt.last   = (stat_q != STAT_RETRY);
      end
      ST_HDR: begin
        rslt.kind = KIND_HDR;
        priority if (arch_q == ARCH_UHL) begin
          rslt.byte_a     = saved_addr_q[23:16];
          rslt.byte_b     = saved_addr_q[15:8];
          rslt.byte_c     = saved_addr_q[7:0];
          rslt.byte_d     = cnt_byte;
          rslt.byte_count = 3'd4;
        end else if (arch_q == ARCH_LHU) begin
          rslt.byte_a     = saved_addr_q[7:0];
          rslt.byte_b     = saved_addr_q[15:8];
          rslt.byte_c     = saved_addr_q[23:16];
          rslt.byte_d     = cnt_byte;
          rslt.byte_count = 3'd4;
        end else begin
          rslt.byte_a     = saved_addr_q[15:8];
          rslt.byte_b     = saved_addr_q[7:0];
          rslt.byte_c     = cnt_byte;
          rslt.byte_count = 3'd3;
        end
      end
      ST_WORD: begin
        rslt.kind   = KIND_WORD;
        rslt.byte_a = word_data[7:0];
        rslt.byte_b = word_data[15:8];
        if (bpw3) begin
          rslt.byte_c     = word_data[23:16];
          rslt.byte_count = 3'd3;
        end else begin
          rslt.byte_count = 3'd2;
        end
        rslt.last = !replay_q && !csum_after_q;
      end
      ST_CSUM: begin
        rslt.kind       = KIND_CSUM;
        rslt.byte_a     = 8'h00 - sum_q;
        rslt.byte_count = 3'd1;
        rslt.last       = 1'b1;
      end
      default: rslt = '0;
    endcase
  end

  // shared byte adder for the running checksum
  assign sum_add = sum_q + rslt.byte_a + rslt.byte_b + rslt.byte_c + rslt.byte_d;

  // sequencer: next state and control
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    sum_d        = sum_q;
    retries_d    = retries_q;
    widx_d       = widx_q;
    rd_idx_d     = rd_idx_q;
    awaiting_d   = awaiting_q;
    saved_addr_d = saved_addr_q;
    replay_d     = replay_q;
    csum_after_d = csum_after_q;
    stat_d       = stat_q;
    emit         = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = widx_q;
    rd_en        = 1'b0;
    start        = in_frame_start || (widx_q == '0);
    widx_eff     = start ? '0 : widx_q;
    complete     = (widx_eff == LAST_IDX);
    retries_eff  = in_image_start ? limit_q : retries_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          retries_d = retries_eff;
          if (in_cmd == CMD_WORD) begin
            if (!awaiting_q) begin
              mem_we       = 1'b1;
              mem_waddr    = widx_eff;
              replay_d     = 1'b0;
              csum_after_d = complete;
              widx_d       = complete ? '0 : widx_eff + 1'b1;
              if (complete) awaiting_d = 1'b1;
              if (start) begin
                saved_addr_d = in_frame_address;
                sum_d        = '0;
                state_d      = ST_HDR;
              end else begin
                state_d = ST_WORD;
              end
            end
          end else if (awaiting_q) begin
            state_d = ST_STAT;
            priority if (in_reply_char == REPLY_OK) begin
              stat_d     = STAT_OK;
              awaiting_d = 1'b0;
            end else if (retries_eff == '0) begin
              stat_d     = STAT_FAIL;
              awaiting_d = 1'b0;
            end else begin
              retries_d = retries_eff - 8'd1;
              stat_d    = STAT_RETRY;
              sum_d     = '0;
              replay_d  = 1'b1;
              rd_idx_d  = '0;
            end
          end
        end
      end
      ST_STAT: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = (stat_q == STAT_RETRY) ? ST_HDR : ST_IDLE;
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          emit    = 1'b1;
          sum_d   = sum_add;
          state_d = replay_q ? ST_RD : ST_WORD;
        end
      end
      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_WORD;
      end
      ST_WORD: begin
        if (slot_free) begin
          emit  = 1'b1;
          sum_d = sum_add;
          if (replay_q) begin
            if (rd_idx_q == LAST_IDX) begin
              state_d = ST_CSUM;
            end else begin
              rd_idx_d = rd_idx_q + 1'b1;
              state_d  = ST_RD;
            end
          end else begin
            state_d = csum_after_q ? ST_CSUM : ST_IDLE;
          end
        end
      end
      ST_CSUM: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) out_valid_d = 1'b1;
  end

  // configuration registers
  always_comb begin
    arch_d  = arch_q;
    bpw_d   = bpw_q;
    limit_d = limit_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_ARCH_MODE:      arch_d  = cfg_data_i[1:0];
        CFG_BYTES_PER_WORD: bpw_d   = cfg_data_i[1:0];
        CFG_RETRY_LIMIT:    limit_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      sum_q        <= '0;
      retries_q    <= LIMIT_RESET;
      widx_q       <= '0;
      rd_idx_q     <= '0;
      awaiting_q   <= 1'b0;
      saved_addr_q <= '0;
      arch_q       <= ARCH_RESET;
      bpw_q        <= BPW_RESET;
      limit_q      <= LIMIT_RESET;
      replay_q     <= 1'b0;
      csum_after_q <= 1'b0;
      stat_q       <= STAT_NONE;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      sum_q        <= sum_d;
      retries_q    <= retries_d;
      widx_q       <= widx_d;
      rd_idx_q     <= rd_idx_d;
      awaiting_q   <= awaiting_d;
      saved_addr_q <= saved_addr_d;
      arch_q       <= arch_d;
      bpw_q        <= bpw_d;
      limit_q      <= limit_d;
      replay_q     <= replay_d;
      csum_after_q <= csum_after_d;
      stat_q       <= stat_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mem_we) cw_q <= in_code_word;
    if (emit) out_q <= rslt;
  end

  // frame buffer for resending
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= in_code_word;
    if (rd_en) rdata_q <= mem[rd_idx_q];
  end

  // output item
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.status, out_q.byte_count,
                          out_q.byte_d, out_q.byte_c, out_q.byte_b, out_q.byte_a};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

  // a frame waiting for its reply has been fully counted out
  a_await_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> (widx_q == '0))
    else $error("awaiting reply with a partial word index");

  // buffer reads happen only during a resend
  a_rd_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> replay_q)
    else $error("buffer read outside a resend");

  // a checksum item carries exactly one byte
  a_csum_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == KIND_CSUM)) |-> (out_q.byte_count == 3'd1))
    else $error("checksum item with wrong byte count");

  // a final status closes the item's results
  a_stat_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == KIND_STAT) && (out_q.status != STAT_RETRY))
      |-> out_q.last)
    else $error("final status not marked last");

endmodule
`default_nettype wire

[verif/boot_frame_sender_retry_core_test.sv]
`timescale 1ns / 100ps

module boot_frame_sender_retry_core_test;
  import bfsr_pkg::*;

  localparam int FRAME_LEN = 32;
  localparam int SETTLE_CYCLES = 160;
  localparam int PRINT_CAP = 60;
  localparam logic [7:0] REPLY_NAK = 8'h4E;

  // frame builder model and the queue of results it still expects
  class frame_tracker;
    logic [1:0]  arch_mode_r;
    logic [1:0]  bpw_r;
    logic [7:0]  retry_limit_r;
    logic [23:0] word_store [FRAME_LEN];
    logic [23:0] frame_addr;
    logic [7:0]  byte_sum;
    logic [7:0]  budget;
    logic [5:0]  widx;
    bit          awaiting;
    int unsigned err_cnt;
    bfsr_rslt_t  results_q [$];

    function new();
      arch_mode_r   = ARCH_RESET;
      bpw_r         = BPW_RESET;
      retry_limit_r = LIMIT_RESET;
      frame_addr    = '0;
      byte_sum      = '0;
      budget        = LIMIT_RESET;
      widx          = '0;
      awaiting      = 1'b0;
      err_cnt       = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [7:0] val);
      case (idx)
        CFG_ARCH_MODE:      arch_mode_r = val[1:0];
        CFG_BYTES_PER_WORD: bpw_r = val[1:0];
        CFG_RETRY_LIMIT:    retry_limit_r = val;
        default: ;
      endcase
    endfunction

    function int unsigned word_len();
      return (bpw_r == BPW_THREE) ? 3 : 2;
    endfunction

    function void queue_result(input bfsr_kind_e kind, input logic [7:0] a, b, c, d,
                               input logic [2:0] n, input bfsr_status_e st);
      bfsr_rslt_t r;
      r.kind       = kind;
      r.byte_a     = a;
      r.byte_b     = b;
      r.byte_c     = c;
      r.byte_d     = d;
      r.byte_count = n;
      r.status     = st;
      r.last       = 1'b0;
      results_q.push_back(r);
    endfunction

    // address in arch order, then the count byte
    function void add_header();
      logic [7:0] lo, hi, up, cnt;
      lo  = frame_addr[7:0];
      hi  = frame_addr[15:8];
      up  = frame_addr[23:16];
      cnt = 8'(word_len() * FRAME_LEN);
      if (arch_mode_r == ARCH_UHL) begin
        queue_result(KIND_HDR, up, hi, lo, cnt, 3'd4, STAT_NONE);
        byte_sum = byte_sum + up + hi + lo + cnt;
      end else if (arch_mode_r == ARCH_LHU) begin
        queue_result(KIND_HDR, lo, hi, up, cnt, 3'd4, STAT_NONE);
        byte_sum = byte_sum + up + hi + lo + cnt;
      end else begin
        queue_result(KIND_HDR, hi, lo, cnt, 8'h00, 3'd3, STAT_NONE);
        byte_sum = byte_sum + hi + lo + cnt;
      end
    endfunction

    function void add_word(input logic [23:0] w);
      if (word_len() == 3) begin
        queue_result(KIND_WORD, w[7:0], w[15:8], w[23:16], 8'h00, 3'd3, STAT_NONE);
        byte_sum = byte_sum + w[7:0] + w[15:8] + w[23:16];
      end else begin
        queue_result(KIND_WORD, w[7:0], w[15:8], 8'h00, 8'h00, 3'd2, STAT_NONE);
        byte_sum = byte_sum + w[7:0] + w[15:8];
      end
    endfunction

    function void add_checksum();
      logic [7:0] neg;
      neg = 8'h00 - byte_sum;
      queue_result(KIND_CSUM, neg, 8'h00, 8'h00, 8'h00, 3'd1, STAT_NONE);
    endfunction

    // an accepted input item: work out the results it causes
    function void take_item(input logic cmd, input logic [63:0] data);
      logic [23:0] code, addr;
      logic        fs, img;
      logic [7:0]  rsp;
      int          prev_cnt;
      code     = data[23:0];
      addr     = data[47:24];
      fs       = data[48];
      img      = data[49];
      rsp      = data[57:50];
      prev_cnt = results_q.size();
      if (img) budget = retry_limit_r;
      if (cmd == CMD_WORD) begin
        if (!awaiting) begin
          if (fs || widx == 0) begin
            widx       = '0;
            frame_addr = addr;
            byte_sum   = '0;
            add_header();
          end
          word_store[widx[4:0]] = code;
          add_word(code);
          widx = widx + 6'd1;
          if (widx >= FRAME_LEN) begin
            add_checksum();
            widx     = '0;
            awaiting = 1'b1;
          end
        end
      end else if (awaiting) begin
        if (rsp == REPLY_OK) begin
          queue_result(KIND_STAT, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, STAT_OK);
          awaiting = 1'b0;
        end else if (budget == 0) begin
          queue_result(KIND_STAT, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, STAT_FAIL);
          awaiting = 1'b0;
        end else begin
          budget = budget - 8'd1;
          queue_result(KIND_STAT, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, STAT_RETRY);
          byte_sum = '0;
          add_header();
          for (int k = 0; k < FRAME_LEN; k++) add_word(word_store[k]);
          add_checksum();
        end
      end
      if (results_q.size() > prev_cnt) results_q[results_q.size() - 1].last = 1'b1;
    endfunction

    task flag_mismatch(input string msg);
      if (err_cnt < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
      err_cnt++;
    endtask

    // compare one accepted result with the oldest expected one
    task check_result(input logic [1:0] kind, input logic [39:0] data, input logic last);
      bfsr_rslt_t exp;
      if (results_q.size() == 0) begin
        flag_mismatch($sformatf("result kind %0d with nothing expected", kind));
      end else begin
        exp = results_q.pop_front();
        if (kind !== exp.kind)
          flag_mismatch($sformatf("kind got %0d want %0d", kind, exp.kind));
        if (data[7:0] !== exp.byte_a)
          flag_mismatch($sformatf("byte_a got %0h want %0h", data[7:0], exp.byte_a));
        if (data[15:8] !== exp.byte_b)
          flag_mismatch($sformatf("byte_b got %0h want %0h", data[15:8], exp.byte_b));
        if (data[23:16] !== exp.byte_c)
          flag_mismatch($sformatf("byte_c got %0h want %0h", data[23:16], exp.byte_c));
        if (data[31:24] !== exp.byte_d)
          flag_mismatch($sformatf("byte_d got %0h want %0h", data[31:24], exp.byte_d));
        if (data[34:32] !== exp.byte_count)
          flag_mismatch($sformatf("byte_count got %0d want %0d", data[34:32],
                                  exp.byte_count));
        if (data[36:35] !== exp.status)
          flag_mismatch($sformatf("status got %0d want %0d", data[36:35], exp.status));
        if (last !== exp.last)
          flag_mismatch($sformatf("last got %0b want %0b", last, exp.last));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i;
  logic [7:0]  cfg_data_i;

  frame_tracker tracker = new();
  bit idle_en = 1'b1;
  bit tx_calm = 1'b0;

  boot_frame_sender_retry_core #(
    .FRAME_WORDS(FRAME_LEN)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_addr_i(cfg_addr_i),
    .cfg_data_i(cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // receiver stalls in short bursts, with calm stretches
  initial begin
    int unsigned hold_cnt;
    bit rx_calm;
    m_axis_tready = 1'b0;
    hold_cnt = 0;
    rx_calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
      if (hold_cnt != 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt--;
      end else if (idle_en && !rx_calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt = $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // run time limit
  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] pack_item(input logic [23:0] code, input logic [23:0] addr,
                                            input logic fs, input logic img,
                                            input logic [7:0] rsp);
    return {6'd0, rsp, img, fs, addr, code};
  endfunction

  // 24-bit value, leaning on the extremes
  function automatic logic [23:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [7:0] rand_nak();
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0: v = REPLY_NAK;
      1: v = 8'h00;
      2: v = 8'hFF;
      3: v = 8'h4A;
      4: v = 8'hCB;
      default: begin
        v = 8'($urandom_range(0, 255));
        if (v == REPLY_OK) v = REPLY_NAK;
      end
    endcase
    return v;
  endfunction

  // one input item, with an occasional gap before it
  task automatic send_item(input logic cmd, input logic [63:0] data);
    @(negedge clk_i);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    if (idle_en && !tx_calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.take_item(cmd, data);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every expected result is out and the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // finish the current frame, then answer it until accepted or failed
  task automatic run_frame(input bit force_nak, input bit reload);
    bit          first_item;
    logic        fs;
    logic        img;
    logic [7:0]  rsp;
    int unsigned naks;
    first_item = 1'b1;
    while (!tracker.awaiting) begin
      // stray reply while no frame is pending
      if ($urandom_range(0, 19) == 0)
        send_item(CMD_REPLY, pack_item(rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 7) == 0),
                                       8'($urandom_range(0, 255))));
      if (tracker.widx == 0) fs = ($urandom_range(0, 3) != 0);
      else fs = ($urandom_range(0, 59) == 0);
      img = (first_item && reload) || ($urandom_range(0, 31) == 0);
      send_item(CMD_WORD, pack_item(rand_word(), rand_word(), fs, img,
                                    8'($urandom_range(0, 255))));
      first_item = 1'b0;
    end
    naks = 0;
    while (tracker.awaiting) begin
      // code word while a reply is pending
      if ($urandom_range(0, 3) == 0)
        send_item(CMD_WORD, pack_item(rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 7) == 0),
                                      8'($urandom_range(0, 255))));
      if (force_nak && naks == 0) rsp = rand_nak();
      else if (naks >= 3 || $urandom_range(0, 1) == 0) rsp = REPLY_OK;
      else rsp = rand_nak();
      send_item(CMD_REPLY, pack_item(rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 15) == 0), rsp));
      naks++;
    end
  endtask

  initial begin
    logic [1:0] arch_set  [6];
    logic [1:0] bpw_set   [6];
    logic [7:0] limit_set [6];
    arch_set  = '{ARCH_HL, ARCH_UHL, ARCH_LHU, 2'd3, ARCH_LHU, ARCH_UHL};
    bpw_set   = '{BPW_RESET, BPW_THREE, BPW_RESET, BPW_THREE, 2'd0, 2'd1};
    limit_set = '{LIMIT_RESET, 8'd0, 8'd255, 8'd1, 8'd2, 8'd3};

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_WORD;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = CFG_ARCH_MODE;
    cfg_data_i    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: stray replies, extreme fields, restart of a partly sent frame
    send_item(CMD_REPLY, pack_item(24'h0, 24'h0, 1'b0, 1'b0, REPLY_OK));
    send_item(CMD_REPLY, pack_item(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 8'hFF));
    send_item(CMD_WORD, pack_item(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 8'hFF));
    send_item(CMD_WORD, pack_item(24'h000000, 24'h000000, 1'b0, 1'b0, 8'h00));
    send_item(CMD_WORD, pack_item(24'h000000, 24'h000000, 1'b1, 1'b0, 8'h00));
    send_item(CMD_WORD, pack_item(24'h800001, 24'h123456, 1'b0, 1'b1, REPLY_NAK));

    // configuration phases with random frames
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        settle();
        write_reg(CFG_ARCH_MODE, {6'd0, arch_set[p]});
        write_reg(CFG_BYTES_PER_WORD, {6'd0, bpw_set[p]});
        write_reg(CFG_RETRY_LIMIT, limit_set[p]);
      end
      if (p == 5) idle_en = 1'b0;
      for (int f = 0; f < 2; f++) run_frame(f == 0, f == 0 && p > 0);
    end

    settle();
    if (tracker.err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
